// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/qmr_pkg.sv =====
package qmr_pkg;

   typedef enum logic {
      OP_HAMILTON = 1'b0,
      OP_ROTATE   = 1'b1
   } opcode_type;

   localparam int unsigned TERMS = 4;

   // For result component k, term t multiplies a[t] by b[TERM_B[k][t]].
   localparam logic [1:0] TERM_B [TERMS][TERMS] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   // Terms of the Hamilton product that enter the sum with a minus sign.
   localparam logic TERM_NEG [TERMS][TERMS] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

endpackage

// ===== design/qmr_hamilton.sv =====
module qmr_hamilton #(
   parameter int unsigned WORD_BITS = 32,
   parameter int unsigned FRAC_BITS = 16,
   parameter bit          CONJ_B    = 1'b0,
   parameter int unsigned SIDE_BITS = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [WORD_BITS-1:0] opa [4],
   input  logic signed [WORD_BITS-1:0] opb [4],
   input  logic [SIDE_BITS-1:0]        side,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [WORD_BITS-1:0] res [4],
   output logic [SIDE_BITS-1:0]        res_side
);
   import qmr_pkg::*;

   localparam int unsigned PROD_BITS = 2 * WORD_BITS;
   localparam int unsigned SUM_BITS  = PROD_BITS + 2;
   localparam logic signed [SUM_BITS-1:0] HALF =
      {{(SUM_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [WORD_BITS-1:0] MAX_WORD = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] MIN_WORD = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic [2:0] valid_ff;
   logic       load_mul, load_sum, load_rnd;

   logic signed [PROD_BITS-1:0] prod_in [TERMS][TERMS];
   logic signed [PROD_BITS-1:0] prod_ff [TERMS][TERMS];
   logic signed [SUM_BITS-1:0]  sum_in  [TERMS];
   logic signed [SUM_BITS-1:0]  sum_ff  [TERMS];
   logic signed [SUM_BITS-1:0]  rnd     [TERMS];
   logic signed [WORD_BITS-1:0] res_in  [TERMS];
   logic signed [WORD_BITS-1:0] res_ff  [TERMS];
   logic [SIDE_BITS-1:0]        side_ff [3];

   // A stage loads when it is empty or its successor moves on.
   assign load_rnd = !valid_ff[2] || out_ready;
   assign load_sum = !valid_ff[1] || load_rnd;
   assign load_mul = !valid_ff[0] || load_sum;
   assign in_ready = load_mul;

   always_comb begin
      for (int k = 0; k < TERMS; k++) begin
         for (int t = 0; t < TERMS; t++) begin
            prod_in[k][t] = PROD_BITS'(opa[t]) * PROD_BITS'(opb[TERM_B[k][t]]);
         end
      end
   end

   // Conjugating b flips the sign of every term that uses b's vector part.
   always_comb begin
      for (int k = 0; k < TERMS; k++) begin
         sum_in[k] = '0;
         for (int t = 0; t < TERMS; t++) begin
            if (TERM_NEG[k][t] ^ (CONJ_B && (TERM_B[k][t] != 2'd0))) begin
               sum_in[k] = sum_in[k] - SUM_BITS'(prod_ff[k][t]);
            end else begin
               sum_in[k] = sum_in[k] + SUM_BITS'(prod_ff[k][t]);
            end
         end
      end
   end

   // Round half up, drop the fraction, then clamp to the word range.
   always_comb begin
      for (int k = 0; k < TERMS; k++) begin
         rnd[k] = sum_ff[k] + HALF;
         if ((&rnd[k][SUM_BITS-1:WORD_BITS+FRAC_BITS-1]) ||
             !(|rnd[k][SUM_BITS-1:WORD_BITS+FRAC_BITS-1])) begin
            res_in[k] = rnd[k][WORD_BITS+FRAC_BITS-1:FRAC_BITS];
         end else if (rnd[k][SUM_BITS-1]) begin
            res_in[k] = MIN_WORD;
         end else begin
            res_in[k] = MAX_WORD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load_mul) valid_ff[0] <= in_valid;
         if (load_sum) valid_ff[1] <= valid_ff[0];
         if (load_rnd) valid_ff[2] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (load_mul) begin
         prod_ff    <= prod_in;
         side_ff[0] <= side;
      end
      if (load_sum) begin
         sum_ff     <= sum_in;
         side_ff[1] <= side_ff[0];
      end
      if (load_rnd) begin
         res_ff     <= res_in;
         side_ff[2] <= side_ff[1];
      end
   end

   assign out_valid = valid_ff[2];
   assign res       = res_ff;
   assign res_side  = side_ff[2];

endmodule

// ===== design/quaternion_multiply_rotate.sv =====
// Quaternion product and rotation unit in signed fixed point (WORD_BITS-bit words with
// FRAC_BITS fraction bits, Q16.16 by default). A request with opcode 0 returns the
// Hamilton product q*p; opcode 1 returns the vector (p_x,p_y,p_z) rotated by q, formed as
// q*(0,v)*conj(q) with each product rounded half up and saturated, r_w forced to zero and
// p_w ignored. q is not normalized, so a rotated vector comes out scaled by the squared
// norm of q. The unit takes one request per clock while the response side does not
// stall, and each result passes through two Hamilton stages of three registers each
// (multiply, signed sum, round and saturate). Backpressure moves back one stage at a
// time, so empty stages keep filling while a finished result waits, and up to six
// requests can be in flight.
module quaternion_multiply_rotate #(
   parameter int unsigned WORD_BITS = 32,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic signed [WORD_BITS-1:0] req_q_w,
   input  logic signed [WORD_BITS-1:0] req_q_x,
   input  logic signed [WORD_BITS-1:0] req_q_y,
   input  logic signed [WORD_BITS-1:0] req_q_z,
   input  logic signed [WORD_BITS-1:0] req_p_w,
   input  logic signed [WORD_BITS-1:0] req_p_x,
   input  logic signed [WORD_BITS-1:0] req_p_y,
   input  logic signed [WORD_BITS-1:0] req_p_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_r_w,
   output logic signed [WORD_BITS-1:0] rsp_r_x,
   output logic signed [WORD_BITS-1:0] rsp_r_y,
   output logic signed [WORD_BITS-1:0] rsp_r_z
);
   import qmr_pkg::*;

   // The sideband carries the opcode and four words alongside each stage.
   localparam int unsigned SIDE_BITS = 1 + 4 * WORD_BITS;

   logic                        rotate;
   logic signed [WORD_BITS-1:0] q_vec   [4];
   logic signed [WORD_BITS-1:0] p_vec   [4];
   logic signed [WORD_BITS-1:0] t_vec   [4];
   logic signed [WORD_BITS-1:0] q_late  [4];
   logic signed [WORD_BITS-1:0] t_late  [4];
   logic signed [WORD_BITS-1:0] r_vec   [4];
   logic [SIDE_BITS-1:0]        side_a, side_a_out, side_b, side_b_out;
   logic                        mid_valid, mid_ready;

   assign rotate = (opcode_type'(req_opcode) == OP_ROTATE);

   assign q_vec[0] = req_q_w;
   assign q_vec[1] = req_q_x;
   assign q_vec[2] = req_q_y;
   assign q_vec[3] = req_q_z;

   // For a rotation the vector enters as a pure quaternion.
   assign p_vec[0] = rotate ? '0 : req_p_w;
   assign p_vec[1] = req_p_x;
   assign p_vec[2] = req_p_y;
   assign p_vec[3] = req_p_z;

   assign side_a = {req_opcode, req_q_w, req_q_x, req_q_y, req_q_z};

   // First stage: q*p for a product, q*(0,v) for a rotation.
   qmr_hamilton #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .CONJ_B    (1'b0),
      .SIDE_BITS (SIDE_BITS)
   ) u_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .opa       (q_vec),
      .opb       (p_vec),
      .side      (side_a),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .res       (t_vec),
      .res_side  (side_a_out)
   );

   // The original q rides along for the second stage.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_late[i] = side_a_out[(3-i)*WORD_BITS +: WORD_BITS];
      end
   end

   assign side_b = {side_a_out[SIDE_BITS-1], t_vec[0], t_vec[1], t_vec[2], t_vec[3]};

   // Second stage: t*conj(q). Its result is used only for rotations; a plain product
   // passes through in the sideband.
   qmr_hamilton #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .CONJ_B    (1'b1),
      .SIDE_BITS (SIDE_BITS)
   ) u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .opa       (t_vec),
      .opb       (q_late),
      .side      (side_b),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .res       (r_vec),
      .res_side  (side_b_out)
   );

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         t_late[i] = side_b_out[(3-i)*WORD_BITS +: WORD_BITS];
      end
   end

   always_comb begin
      if (opcode_type'(side_b_out[SIDE_BITS-1]) == OP_ROTATE) begin
         rsp_r_w = '0;
         rsp_r_x = r_vec[1];
         rsp_r_y = r_vec[2];
         rsp_r_z = r_vec[3];
      end else begin
         rsp_r_w = t_late[0];
         rsp_r_x = t_late[1];
         rsp_r_y = t_late[2];
         rsp_r_z = t_late[3];
      end
   end

endmodule

// ===== design/qmr_checker.sv =====
`include "assert_macros.svh"

module qmr_checker #(
   parameter int unsigned WORD_BITS = 32
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [WORD_BITS-1:0] rsp_r_w,
   input logic signed [WORD_BITS-1:0] rsp_r_x,
   input logic signed [WORD_BITS-1:0] rsp_r_y,
   input logic signed [WORD_BITS-1:0] rsp_r_z
);

   logic [3:0] count_ff, count_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (req_take && !rsp_take) begin
         count_in = count_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_r_w) && $stable(rsp_r_x) && $stable(rsp_r_y) &&
      $stable(rsp_r_z), "stalled response changed")

   `ASSERT_SAME(a_no_phantom, clock, reset, count_ff == 4'd0, !rsp_valid,
      "response with no request in flight")

   `ASSERT_SAME(a_flow_through, clock, reset, rsp_ready, req_ready,
      "request stalled while response side is ready")

endmodule

bind quaternion_multiply_rotate qmr_checker #(.WORD_BITS(WORD_BITS)) u_qmr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_r_w   (rsp_r_w),
   .rsp_r_x   (rsp_r_x),
   .rsp_r_y   (rsp_r_y),
   .rsp_r_z   (rsp_r_z)
);

// ===== verif/quaternion_multiply_rotate_tb.sv =====
// Self-checking testbench for the quaternion product and rotation unit.
//
// Requests go in on the req_ channel and results come back on the rsp_ channel. Both use
// a valid/ready handshake. The unit keeps no state, so every accepted request maps to one
// result, and results come back in request order. The bench works out the expected
// quaternion for each request as it is accepted and puts it in a FIFO. The response
// monitor pops the oldest entry and compares it with the result, field by field.
module quaternion_multiply_rotate_tb;
   import qmr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WB = 32;
   localparam int unsigned FB = 16;

   // The drain at the end waits for longer than the unit needs to return a result when
   // nothing stalls.
   localparam int unsigned DRAIN_CYCLES    = 12;
   // Cycles in a row with no handshake on either channel before the run is declared hung.
   // The longest correct gap is the deliberate receiver hold-off, well below this.
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned HOLD_OFF_CYCLES = 80;

   typedef logic signed [WB-1:0] word_type;

   typedef struct packed {
      word_type w;
      word_type x;
      word_type y;
      word_type z;
   } quat_type;

   typedef struct {
      opcode_type op;
      quat_type   q;
      quat_type   p;
   } request_type;

   localparam word_type WORD_MAX = {1'b0, {(WB-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WB-1){1'b0}}};
   localparam word_type ONE      = word_type'(1) <<< FB;
   // cos(45 degrees) in Q16.16, so that (C45, 0, 0, C45) turns a vector by about 90
   // degrees about z.
   localparam word_type C45      = 32'sh0000_B505;

   // Each product term is at most 34 bits by 34 bits, and four of them are summed, so
   // 72 bits hold every sum exactly.
   localparam logic signed [71:0] ROUND_HALF = 72'sd1 <<< (FB - 1);
   localparam logic signed [71:0] SAT_HI     = (72'sd1 <<< (WB - 1)) - 72'sd1;
   localparam logic signed [71:0] SAT_LO     = -(72'sd1 <<< (WB - 1));

   logic  clock = 1'b0;
   logic  reset = 1'b1;

   logic     req_valid  = 1'b0;
   logic     req_ready;
   logic     req_opcode = 1'b0;
   word_type req_q_w    = '0;
   word_type req_q_x    = '0;
   word_type req_q_y    = '0;
   word_type req_q_z    = '0;
   word_type req_p_w    = '0;
   word_type req_p_x    = '0;
   word_type req_p_y    = '0;
   word_type req_p_z    = '0;

   logic     rsp_valid;
   logic     rsp_ready  = 1'b0;
   word_type rsp_r_w;
   word_type rsp_r_x;
   word_type rsp_r_y;
   word_type rsp_r_z;

   // Expected results, oldest first, one per accepted request.
   quat_type    pending_results[$];

   int unsigned error_count        = 0;
   int unsigned products_sent      = 0;
   int unsigned rotations_sent     = 0;
   int unsigned results_checked    = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned idle_streak        = 0;

   // These idle rates are percentages. The test sequence sets them, and the sender and
   // the receiver read them.
   int unsigned send_idle_pct      = 0;
   int unsigned recv_idle_pct      = 0;

   // A test asks for a long receiver hold-off by bumping the request count. The receiver
   // process notices the change and counts the stall out by itself.
   int unsigned hold_off_requests  = 0;
   int unsigned hold_off_served    = 0;
   int unsigned hold_off_left      = 0;

   quaternion_multiply_rotate #(
      .WORD_BITS(WB),
      .FRAC_BITS(FB)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_opcode(req_opcode),
      .req_q_w   (req_q_w),
      .req_q_x   (req_q_x),
      .req_q_y   (req_q_y),
      .req_q_z   (req_q_z),
      .req_p_w   (req_p_w),
      .req_p_x   (req_p_x),
      .req_p_y   (req_p_y),
      .req_p_z   (req_p_z),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_r_w   (rsp_r_w),
      .rsp_r_x   (rsp_r_x),
      .rsp_r_y   (rsp_r_y),
      .rsp_r_z   (rsp_r_z)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Expected results
   // ---------------------------------------------------------------------------------

   // The sum is rounded half toward plus infinity, shifted down to Q16.16 and then
   // clamped to the signed word range.
   function automatic word_type round_saturate(input logic signed [71:0] acc);
      logic signed [71:0] scaled;
      scaled = (acc + ROUND_HALF) >>> FB;
      if (scaled > SAT_HI)
         return WORD_MAX;
      if (scaled < SAT_LO)
         return WORD_MIN;
      return scaled[WB-1:0];
   endfunction

   // This is one Hamilton product stage, a*b, or a*conj(b) when conj_b is set. The
   // operands are widened to 34 bits before the conjugate is taken. The negation is then
   // exact even when a vector component of b is the most negative word.
   function automatic quat_type hamilton_stage(input quat_type a, input quat_type b,
                                               input bit conj_b);
      logic signed [33:0] aw, ax, ay, az, bw, bx, by, bz;
      logic signed [71:0] sw, sx, sy, sz;
      quat_type           r;
      aw = $signed(a.w);
      ax = $signed(a.x);
      ay = $signed(a.y);
      az = $signed(a.z);
      bw = $signed(b.w);
      bx = $signed(b.x);
      by = $signed(b.y);
      bz = $signed(b.z);
      if (conj_b) begin
         bx = -bx;
         by = -by;
         bz = -bz;
      end
      sw = aw * bw - ax * bx - ay * by - az * bz;
      sx = aw * bx + ax * bw + ay * bz - az * by;
      sy = aw * by - ax * bz + ay * bw + az * bx;
      sz = aw * bz + ax * by - ay * bx + az * bw;
      r.w = round_saturate(sw);
      r.x = round_saturate(sx);
      r.y = round_saturate(sy);
      r.z = round_saturate(sz);
      return r;
   endfunction

   // A rotation is q*(0,v)*conj(q). Each stage is rounded and saturated by itself, p_w
   // plays no part, and the scalar of the result is forced to zero.
   function automatic quat_type compute_quat_result(input request_type rq);
      quat_type vec;
      quat_type res;
      if (rq.op == OP_HAMILTON) begin
         res = hamilton_stage(rq.q, rq.p, 1'b0);
      end else begin
         vec   = rq.p;
         vec.w = '0;
         res   = hamilton_stage(hamilton_stage(rq.q, vec, 1'b0), rq.q, 1'b1);
         res.w = '0;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request construction
   // ---------------------------------------------------------------------------------

   function automatic request_type make_request(input opcode_type op,
                                                input word_type qw, input word_type qx,
                                                input word_type qy, input word_type qz,
                                                input word_type pw, input word_type px,
                                                input word_type py, input word_type pz);
      request_type rq;
      rq.op = op;
      rq.q  = '{w: qw, x: qx, y: qy, z: qz};
      rq.p  = '{w: pw, x: px, y: py, z: pz};
      return rq;
   endfunction

   // Values fall into three groups. Some are corner words. Some are full-range words,
   // which saturate often and toggle every bit. Most are moderate values within +/-4.0,
   // so that both stages of a rotation usually stay in range and the rounding is really
   // exercised.
   function automatic word_type random_word();
      word_type v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0:       v = WORD_MAX;
               1:       v = WORD_MIN;
               2:       v = '0;
               3:       v = '1;
               default: v = ONE;
            endcase
         end
         1, 2, 3: v = $urandom;
         default: begin
            v = $urandom_range(32'h0008_0000);
            v = v - 32'sh0004_0000;
         end
      endcase
      return v;
   endfunction

   function automatic request_type random_request();
      request_type rq;
      rq.op = $urandom_range(1) ? OP_ROTATE : OP_HAMILTON;
      rq.q  = '{w: random_word(), x: random_word(), y: random_word(), z: random_word()};
      rq.p  = '{w: random_word(), x: random_word(), y: random_word(), z: random_word()};
      return rq;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------------------

   // This task drives one request and returns at the edge where it is accepted. Valid is
   // lowered only for an optional idle gap before the request; each cycle of the gap is
   // drawn on its own, so the sender idles in about the given share of its cycles.
   // Back-to-back requests therefore keep valid high, and valid never gets two
   // assignments in one time step.
   task automatic send_request(input request_type rq);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= rq.op;
      req_q_w    <= rq.q.w;
      req_q_x    <= rq.q.x;
      req_q_y    <= rq.q.y;
      req_q_z    <= rq.q.z;
      req_p_w    <= rq.p.w;
      req_p_x    <= rq.p.x;
      req_p_y    <= rq.p.y;
      req_p_z    <= rq.p.z;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_results.push_back(compute_quat_result(rq));
      if (rq.op == OP_HAMILTON)
         products_sent++;
      else
         rotations_sent++;
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // This test covers hand-picked cases:
   // - identities and basis products;
   // - known rotations, including one with a nonzero p_w that must be ignored;
   // - rounding exactly at one half, both signs;
   // - saturation both ways;
   // - a non-unit q scaling the rotated vector;
   // - the most negative word inside a conjugate;
   // - words of all ones, all zeros, and the extremes.
   task automatic test_corner_cases();
      request_type cases[$];
      send_idle_pct = 0;
      recv_idle_pct = 0;
      cases.push_back(make_request(OP_HAMILTON, 0, 0, 0, 0, 0, 0, 0, 0));
      cases.push_back(make_request(OP_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0));
      cases.push_back(make_request(OP_HAMILTON, ONE, 0, 0, 0,
                                   ONE + (ONE >>> 1), -2 * ONE, 3 * ONE, -(ONE >>> 2)));
      cases.push_back(make_request(OP_HAMILTON, 5 * ONE, -7 * ONE, ONE >>> 3, 12345,
                                   ONE, 0, 0, 0));
      cases.push_back(make_request(OP_HAMILTON, 0, ONE, 0, 0, 0, 0, ONE, 0));
      cases.push_back(make_request(OP_HAMILTON, 0, 0, ONE, 0, 0, ONE, 0, 0));
      cases.push_back(make_request(OP_ROTATE, ONE, 0, 0, 0, 9 * ONE, ONE, -2 * ONE, 3 * ONE));
      cases.push_back(make_request(OP_ROTATE, C45, 0, 0, C45, WORD_MAX, ONE, 0, 0));
      cases.push_back(make_request(OP_ROTATE, 0, ONE, 0, 0, WORD_MIN, ONE, 2 * ONE, 3 * ONE));
      // Rounding exactly at one half: +0.5 LSB rounds up, -0.5 LSB rounds up to zero.
      cases.push_back(make_request(OP_HAMILTON, 1, 0, 0, 0, 32'sh8000, 32'sh7FFF, -32'sh8000,
                                   -32'sh8001));
      cases.push_back(make_request(OP_HAMILTON, -1, 0, 0, 0, 32'sh8000, 32'sh18000, 3, -3));
      cases.push_back(make_request(OP_HAMILTON, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                   WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      cases.push_back(make_request(OP_HAMILTON, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                                   WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
      cases.push_back(make_request(OP_HAMILTON, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                   WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
      cases.push_back(make_request(OP_HAMILTON, WORD_MAX, 0, 0, 0, WORD_MIN, ONE, -ONE, 0));
      cases.push_back(make_request(OP_ROTATE, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                                   0, WORD_MAX, WORD_MAX, WORD_MAX));
      // The conjugate of a q whose vector part is the most negative word must not wrap.
      cases.push_back(make_request(OP_ROTATE, 0, WORD_MIN, 0, 0, 0, 1, -1, 2));
      cases.push_back(make_request(OP_ROTATE, ONE >>> 8, 0, WORD_MIN, ONE, 0,
                                   ONE, ONE >>> 4, -ONE));
      cases.push_back(make_request(OP_ROTATE, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                   WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      cases.push_back(make_request(OP_ROTATE, 2 * ONE, 0, 0, 0, 0, ONE, -ONE, ONE >>> 1));
      cases.push_back(make_request(OP_ROTATE, ONE, ONE, ONE, ONE, -ONE, 3 * ONE, ONE, -ONE));
      cases.push_back(make_request(OP_HAMILTON, '1, '1, '1, '1, '1, '1, '1, '1));
      cases.push_back(make_request(OP_ROTATE, '1, '1, '1, '1, '1, '1, '1, '1));
      // The first rotation stage saturates, and the second one scales the clamped value.
      cases.push_back(make_request(OP_ROTATE, 300 * ONE, 0, 0, 0, 0,
                                   WORD_MAX, -(200 * ONE), ONE));
      foreach (cases[i])
         send_request(cases[i]);
   endtask

   // This test sends random traffic with the given idle rates on each side.
   task automatic test_random_traffic(input int unsigned sender_idle,
                                      input int unsigned receiver_idle,
                                      input int unsigned count);
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      repeat (count)
         send_request(random_request());
   endtask

   // The receiver holds off for a long stretch while requests keep coming. The pipeline
   // fills, req_ready drops, and the unit has to resume cleanly with no request lost.
   task automatic test_full_pipeline_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_requests++;
      repeat (40)
         send_request(random_request());
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver, result checker and watchdog
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_off_left   <= HOLD_OFF_CYCLES - 1;
         rsp_ready       <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ready     <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_word(input string name, input word_type want, input word_type got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         error_count++;
      end
   endtask

   // Sampling at the rising edge sees the values from before that edge on both sides of
   // the handshake, so the checker agrees with the unit on which results were accepted.
   always @(posedge clock) begin
      quat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding: %h %h %h %h",
                   rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_word("r_w", want.w, rsp_r_w);
            check_word("r_x", want.x, rsp_r_x);
            check_word("r_y", want.y, rsp_r_y);
            check_word("r_z", want.z, rsp_r_z);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (req_valid && !req_ready)
         input_stall_cycles++;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_streak <= 0;
      end else if (idle_streak >= WATCHDOG_LIMIT) begin
         $display("quaternion_multiply_rotate verification failed");
         $finish;
      end else begin
         idle_streak <= idle_streak + 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_corner_cases();
      // The sender is mostly busy and the receiver mostly stalled, then the reverse, then
      // both run flat out.
      test_random_traffic(38, 87, 450);
      test_random_traffic(87, 38, 450);
      test_random_traffic(0, 0, 400);
      test_full_pipeline_stall();

      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d Hamilton products and %0d vector rotations, %0d results checked.",
               products_sent, rotations_sent, results_checked);
      $display("Input was held off by backpressure for %0d cycles.", input_stall_cycles);
      if (error_count == 0)
         $display("quaternion_multiply_rotate verification clean");
      else
         $display("quaternion_multiply_rotate verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/qmr_pkg.sv
design/qmr_hamilton.sv
design/quaternion_multiply_rotate.sv
design/qmr_checker.sv
verif/quaternion_multiply_rotate_tb.sv
